@@ design/pmf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package pmf_pkg;

    localparam int FIFO_DEPTH = 16;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int COUNT_W    = $clog2(FIFO_DEPTH + 1);

    localparam int CMD_W   = 3;
    localparam int BYTE_W  = 8;
    localparam int POS_W   = 32;
    localparam int CNT_OUT_W = 5;
    localparam int DIM_W   = 16;
    localparam int PHASE_W = 2;

    localparam logic [BYTE_W-1:0]  EMPTY_BYTE = 8'hff;
    localparam logic [PHASE_W-1:0] LAST_PHASE = 2'd2;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 16'd1024;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 16'd768;

    typedef enum logic [CMD_W-1:0] {
        CMD_DATA   = 3'd0,
        CMD_POP    = 3'd1,
        CMD_SET_X  = 3'd2,
        CMD_SET_Y  = 3'd3,
        CMD_CENTRE = 3'd4
    } cmd_t;

    typedef enum logic [0:0] {
        REG_SCREEN_WIDTH  = 1'b0,
        REG_SCREEN_HEIGHT = 1'b1
    } reg_idx_t;

    // status FIFO storage access
    typedef struct packed {
        logic              wr_en;
        logic [PTR_W-1:0]  wr_addr;
        logic [BYTE_W-1:0] wr_data;
        logic              rd_en;
        logic [PTR_W-1:0]  rd_addr;
    } ram_ctrl_t;

    // per-item result, state after the step (popped byte comes from the RAM)
    typedef struct packed {
        logic                 pop_hit;
        logic                 packet_done;
        logic [BYTE_W-1:0]    last_status;
        logic [POS_W-1:0]     cursor_x;
        logic [POS_W-1:0]     cursor_y;
        logic [CNT_OUT_W-1:0] buffered_count;
    } result_t;

endpackage
`default_nettype wire

@@ design/pmf_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module pmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ design/pmf_decoder.sv @@
`timescale 1ns / 1ps
`default_nettype none
module pmf_decoder (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         accept,
    input  wire logic [pmf_pkg::CMD_W-1:0]    command,
    input  wire logic [pmf_pkg::BYTE_W-1:0]   data_byte,
    input  wire logic [pmf_pkg::POS_W-1:0]    position_value,
    input  wire logic [pmf_pkg::DIM_W-1:0]    screen_width,
    input  wire logic [pmf_pkg::DIM_W-1:0]    screen_height,
    output pmf_pkg::ram_ctrl_t                ram_ctrl,
    output pmf_pkg::result_t                  result
);

    logic [pmf_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [pmf_pkg::BYTE_W-1:0]  first_reg, first_next;
    logic [pmf_pkg::BYTE_W-1:0]  xdelta_reg, xdelta_next;
    logic [pmf_pkg::BYTE_W-1:0]  status_reg, status_next;
    logic [pmf_pkg::POS_W-1:0]   pos_x_reg, pos_x_next;
    logic [pmf_pkg::POS_W-1:0]   pos_y_reg, pos_y_next;
    logic [pmf_pkg::PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [pmf_pkg::PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [pmf_pkg::COUNT_W-1:0] count_reg, count_next;

    logic push, pop_hit, done;

    function automatic logic [pmf_pkg::PTR_W-1:0] bump(input logic [pmf_pkg::PTR_W-1:0] p);
        logic [pmf_pkg::PTR_W-1:0] r;
        if (p == pmf_pkg::PTR_W'(pmf_pkg::FIFO_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    always_comb begin
        phase_next  = phase_reg;
        first_next  = first_reg;
        xdelta_next = xdelta_reg;
        status_next = status_reg;
        pos_x_next  = pos_x_reg;
        pos_y_next  = pos_y_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        push        = 1'b0;
        pop_hit     = 1'b0;
        done        = 1'b0;
        unique case (command)
            pmf_pkg::CMD_DATA: begin
                if (phase_reg >= pmf_pkg::LAST_PHASE) begin
                    phase_next  = '0;
                    status_next = first_reg;
                    pos_x_next  = pos_x_reg + {{(pmf_pkg::POS_W-8){xdelta_reg[7]}}, xdelta_reg};
                    pos_y_next  = pos_y_reg - {{(pmf_pkg::POS_W-8){data_byte[7]}}, data_byte};
                    done        = 1'b1;
                    if (count_reg < pmf_pkg::COUNT_W'(pmf_pkg::FIFO_DEPTH)) begin
                        push        = 1'b1;
                        wr_ptr_next = bump(wr_ptr_reg);
                        count_next  = count_reg + 1'b1;
                    end
                end else begin
                    if (phase_reg == '0) begin
                        first_next = data_byte;
                    end else begin
                        xdelta_next = data_byte;
                    end
                    phase_next = phase_reg + 1'b1;
                end
            end
            pmf_pkg::CMD_POP: begin
                if (count_reg != '0) begin
                    pop_hit     = 1'b1;
                    rd_ptr_next = bump(rd_ptr_reg);
                    count_next  = count_reg - 1'b1;
                end
            end
            pmf_pkg::CMD_SET_X: pos_x_next = position_value;
            pmf_pkg::CMD_SET_Y: pos_y_next = position_value;
            pmf_pkg::CMD_CENTRE: begin
                pos_x_next = pmf_pkg::POS_W'(screen_width >> 1);
                pos_y_next = pmf_pkg::POS_W'(screen_height >> 1);
                phase_next = '0;
            end
            default: ;  // unused codes leave the state alone
        endcase
    end

    // a push writes entry wr_ptr, a pop reads rd_ptr; one command per item,
    // so a read never lands on the entry written in the same cycle
    assign ram_ctrl.wr_en   = accept && push;
    assign ram_ctrl.wr_addr = wr_ptr_reg;
    assign ram_ctrl.wr_data = first_reg;
    assign ram_ctrl.rd_en   = accept && pop_hit;
    assign ram_ctrl.rd_addr = rd_ptr_reg;

    assign result.pop_hit        = pop_hit;
    assign result.packet_done    = done;
    assign result.last_status    = status_next;
    assign result.cursor_x       = pos_x_next;
    assign result.cursor_y       = pos_y_next;
    assign result.buffered_count = pmf_pkg::CNT_OUT_W'(count_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= '0;
            first_reg  <= '0;
            xdelta_reg <= '0;
            status_reg <= '0;
            pos_x_reg  <= '0;
            pos_y_reg  <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            first_reg  <= first_next;
            xdelta_reg <= xdelta_next;
            status_reg <= status_next;
            pos_x_reg  <= pos_x_next;
            pos_y_reg  <= pos_y_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= pmf_pkg::COUNT_W'(pmf_pkg::FIFO_DEPTH))
        else $error("fifo count above depth");

    a_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && command == pmf_pkg::CMD_POP && count_reg == '0)
        |=> ($stable(count_reg) && $stable(rd_ptr_reg)))
        else $error("pop on empty fifo changed state");

    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && pop_hit) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("pop did not decrement count");

    a_full_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && done && count_reg == pmf_pkg::COUNT_W'(pmf_pkg::FIFO_DEPTH))
        |-> !ram_ctrl.wr_en)
        else $error("write into full fifo");

endmodule
`default_nettype wire

@@ design/ps2_mouse_packet_fifo_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Handshake          Contents
// s_ (in)   in   s_tvalid/s_tready  tuser: command; tdata: data_byte, position_value
// m_ (out)  out  m_tvalid/m_tready  tuser: popped_valid, packet_done; tdata: results
// cfg       in   cfg_wr_en          cfg_index selects screen_width or screen_height
//
// One item per cycle unless the result is stalled, one result per item: the decoder
// updates its registers and issues the status RAM access at the accept edge,
// and the result register loads at that same edge.
// The popped byte comes straight from the RAM's registered read port, which is
// only enabled by a successful pop, so it holds while the result is stalled.
// Input is taken whenever the result register is empty or being drained.
// Reset (aresetn low, synchronous) clears pointers, count, positions and phase;
// the status RAM is not cleared, a pop only reads entries already written.
module ps2_mouse_packet_fifo_unit (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // configuration writes
    input  wire logic                       cfg_wr_en,
    input  wire logic [0:0]                 cfg_index,
    input  wire logic [pmf_pkg::DIM_W-1:0]  cfg_wdata,
    // input items
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [39:0]                s_tdata,   // [7:0] data_byte, [39:8] position_value
    input  wire logic [2:0]                 s_tuser,   // [2:0] command
    // result items
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [87:0]                     m_tdata,   // [7:0] popped_byte,
                                                       // [15:8] last_status,
                                                       // [47:16] cursor_x,
                                                       // [79:48] cursor_y,
                                                       // [84:80] buffered_count,
                                                       // [87:85] zero
    output logic [1:0]                      m_tuser    // [0] popped_valid, [1] packet_done
);

    logic [pmf_pkg::DIM_W-1:0] width_reg;
    logic [pmf_pkg::DIM_W-1:0] height_reg;

    logic                      accept;
    pmf_pkg::ram_ctrl_t        ram_ctrl;
    pmf_pkg::result_t          result;
    pmf_pkg::result_t          out_reg;
    logic                      out_valid_reg;
    logic [pmf_pkg::BYTE_W-1:0] ram_rdata;
    logic [pmf_pkg::BYTE_W-1:0] popped_byte;

    // single result stage: refill in the same cycle it drains
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= pmf_pkg::WIDTH_RESET;
            height_reg <= pmf_pkg::HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                pmf_pkg::REG_SCREEN_WIDTH:  width_reg  <= cfg_wdata;
                pmf_pkg::REG_SCREEN_HEIGHT: height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    pmf_decoder u_decoder (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .command        (s_tuser),
        .data_byte      (s_tdata[7:0]),
        .position_value (s_tdata[39:8]),
        .screen_width   (width_reg),
        .screen_height  (height_reg),
        .ram_ctrl       (ram_ctrl),
        .result         (result)
    );

    pmf_ram #(
        .WIDTH (pmf_pkg::BYTE_W),
        .DEPTH (pmf_pkg::FIFO_DEPTH)
    ) u_status_ram (
        .aclk    (aclk),
        .wr_en   (ram_ctrl.wr_en),
        .wr_addr (ram_ctrl.wr_addr),
        .wr_data (ram_ctrl.wr_data),
        .rd_en   (ram_ctrl.rd_en),
        .rd_addr (ram_ctrl.rd_addr),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= result;
        end
    end

    assign popped_byte = out_reg.pop_hit ? ram_rdata : pmf_pkg::EMPTY_BYTE;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg.buffered_count, out_reg.cursor_y,
                       out_reg.cursor_x, out_reg.last_status, popped_byte};
    assign m_tuser  = {out_reg.packet_done, out_reg.pop_hit};

    a_pop_or_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("pop and packet completion in one item");

    a_empty_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[7:0] == pmf_pkg::EMPTY_BYTE))
        else $error("popped byte not empty marker without a pop");

    a_hold_rdata: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(ram_rdata))
        else $error("status RAM read data changed under a stall");

endmodule
`default_nettype wire
